// ===== rtl/core/brse_pkg.sv =====
// shared types and constants for the binary radix sort engine
package brse_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);
    localparam int SEL_W      = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [BIT_W-1:0]  bitpos_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_NORM,
        ST_SCAN,
        ST_RET,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

// ===== rtl/core/brse_ram.sv =====
// generic simple dual-port ram with registered read
module brse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/binary_radix_sort_engine.sv =====
// binary radix sort engine top level: load, normalize, lsb-first passes, emit
//
//  channel  | dir | tdata                        | tlast
//  ---------+-----+------------------------------+---------------------------
//  s_       | in  | [31:0] value (signed)        | last element, starts sort
//  m_       | out | [31:0] sorted_value          | end_of_run
//
// loading takes one word per cycle; the last word starts the sort
// a sort normalizes the words, then runs up to 32 radix passes (a scan of the
// main ram, then a return from the side ram), then emits the words, reading
// each one from the main ram before loading it out: the single read port of
// each ram sets the pace
// aresetn is synchronous and active low; rams need no clearing
// s_tready is high only while loading; a stalled m_ side holds the emitter
module binary_radix_sort_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast
);

    brse_pkg::state_t  state_reg, state_next;
    brse_pkg::cnt_t    n_reg, n_next;
    brse_pkg::cnt_t    rk_reg, rk_next;
    brse_pkg::cnt_t    zc_reg, zc_next;
    brse_pkg::cnt_t    no_reg, no_next;
    brse_pkg::addr_t   wi_reg, wi_next;
    logic              pend_reg, pend_next;
    logic signed [31:0] min_reg, min_next;
    brse_pkg::bitpos_t bit_reg, bit_next;
    logic              sorted_reg, sorted_next;
    logic              first_reg, first_next;
    brse_pkg::word_t   prev_reg, prev_next;
    logic              m_tvalid_reg, m_tvalid_next;
    brse_pkg::word_t   m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              main_we, main_re, side_we, side_re;
    brse_pkg::addr_t   main_waddr, main_raddr, side_waddr, side_raddr;
    brse_pkg::word_t   main_wdata, main_rdata, side_wdata, side_rdata;

    logic              s_fire, issue, done, out_free;
    brse_pkg::word_t   wval;
    brse_pkg::cnt_t    ones_addr, ret_off, ret_addr;

    brse_ram #(.WIDTH(brse_pkg::DATA_W), .DEPTH(brse_pkg::MAX_ITEMS)) u_main (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .re    (main_re),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    brse_ram #(.WIDTH(brse_pkg::DATA_W), .DEPTH(brse_pkg::MAX_ITEMS)) u_side (
        .aclk  (aclk),
        .we    (side_we),
        .waddr (side_waddr),
        .wdata (side_wdata),
        .re    (side_re),
        .raddr (side_raddr),
        .rdata (side_rdata)
    );

    assign s_tready = (state_reg == brse_pkg::ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign issue    = (rk_reg != n_reg);
    assign done     = (rk_reg == n_reg) && !pend_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // ones fill the side ram from the top down
    assign ones_addr = brse_pkg::cnt_t'(brse_pkg::MAX_ITEMS - 1) - no_reg;
    assign ret_off   = rk_reg - zc_reg;
    assign ret_addr  = (rk_reg < zc_reg) ? rk_reg
                     : brse_pkg::cnt_t'(brse_pkg::MAX_ITEMS - 1) - ret_off;

    assign wval = (state_reg == brse_pkg::ST_NORM) ? main_rdata - brse_pkg::word_t'(min_reg)
                                                   : side_rdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brse_pkg::ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = brse_pkg::ST_NORM;
                end
            end
            brse_pkg::ST_NORM: begin
                if (done) begin
                    state_next = sorted_reg ? brse_pkg::ST_EMIT_RD : brse_pkg::ST_SCAN;
                end
            end
            brse_pkg::ST_SCAN: begin
                if (done) begin
                    state_next = brse_pkg::ST_RET;
                end
            end
            brse_pkg::ST_RET: begin
                if (done) begin
                    if (sorted_reg ||
                        (bit_reg + brse_pkg::bitpos_t'(1) ==
                         brse_pkg::bitpos_t'(brse_pkg::VALUE_BITS))) begin
                        state_next = brse_pkg::ST_EMIT_RD;
                    end else begin
                        state_next = brse_pkg::ST_SCAN;
                    end
                end
            end
            brse_pkg::ST_EMIT_RD: begin
                state_next = brse_pkg::ST_EMIT_LD;
            end
            brse_pkg::ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = (rk_reg == n_reg) ? brse_pkg::ST_LOAD : brse_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                state_next = brse_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        main_we       = 1'b0;
        main_waddr    = wi_reg;
        main_wdata    = wval;
        main_re       = 1'b0;
        main_raddr    = rk_reg[brse_pkg::ADDR_W-1:0];
        side_we       = 1'b0;
        side_waddr    = zc_reg[brse_pkg::ADDR_W-1:0];
        side_wdata    = main_rdata;
        side_re       = 1'b0;
        side_raddr    = ret_addr[brse_pkg::ADDR_W-1:0];
        n_next        = n_reg;
        rk_next       = rk_reg;
        zc_next       = zc_reg;
        no_next       = no_reg;
        wi_next       = wi_reg;
        pend_next     = 1'b0;
        min_next      = min_reg;
        bit_next      = bit_reg;
        sorted_next   = sorted_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            brse_pkg::ST_LOAD: begin
                if (s_fire) begin
                    // words past the ram depth are dropped
                    if (n_reg < brse_pkg::cnt_t'(brse_pkg::MAX_ITEMS)) begin
                        main_we    = 1'b1;
                        main_waddr = n_reg[brse_pkg::ADDR_W-1:0];
                        main_wdata = s_tdata;
                        n_next     = n_reg + brse_pkg::cnt_t'(1);
                        if ($signed(s_tdata) < min_reg) begin
                            min_next = $signed(s_tdata);
                        end
                    end
                    if (s_tlast) begin
                        rk_next     = '0;
                        bit_next    = '0;
                        sorted_next = 1'b1;
                        first_next  = 1'b1;
                    end
                end
            end
            brse_pkg::ST_NORM, brse_pkg::ST_RET: begin
                if (issue) begin
                    if (state_reg == brse_pkg::ST_NORM) begin
                        main_re = 1'b1;
                    end else begin
                        side_re = 1'b1;
                    end
                    rk_next   = rk_reg + brse_pkg::cnt_t'(1);
                    wi_next   = rk_reg[brse_pkg::ADDR_W-1:0];
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    main_we    = 1'b1;
                    main_waddr = wi_reg;
                    main_wdata = wval;
                    if (!first_reg && (prev_reg > wval)) begin
                        sorted_next = 1'b0;
                    end
                    prev_next  = wval;
                    first_next = 1'b0;
                end
                if (done) begin
                    rk_next     = '0;
                    zc_next     = '0;
                    no_next     = '0;
                    sorted_next = 1'b1;
                    first_next  = 1'b1;
                    if (state_reg == brse_pkg::ST_RET) begin
                        bit_next = bit_reg + brse_pkg::bitpos_t'(1);
                    end
                end
            end
            brse_pkg::ST_SCAN: begin
                if (issue) begin
                    main_re   = 1'b1;
                    rk_next   = rk_reg + brse_pkg::cnt_t'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    side_we = 1'b1;
                    if (main_rdata[bit_reg[brse_pkg::SEL_W-1:0]]) begin
                        side_waddr = ones_addr[brse_pkg::ADDR_W-1:0];
                        no_next    = no_reg + brse_pkg::cnt_t'(1);
                    end else begin
                        side_waddr = zc_reg[brse_pkg::ADDR_W-1:0];
                        zc_next    = zc_reg + brse_pkg::cnt_t'(1);
                    end
                end
                if (done) begin
                    rk_next     = '0;
                    sorted_next = 1'b1;
                    first_next  = 1'b1;
                end
            end
            brse_pkg::ST_EMIT_RD: begin
                main_re = 1'b1;
                rk_next = rk_reg + brse_pkg::cnt_t'(1);
            end
            brse_pkg::ST_EMIT_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = main_rdata;
                    m_tlast_next  = (rk_reg == n_reg);
                    if (rk_reg == n_reg) begin
                        n_next   = '0;
                        rk_next  = '0;
                        min_next = '0;
                        bit_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= brse_pkg::ST_LOAD;
            n_reg        <= '0;
            rk_reg       <= '0;
            zc_reg       <= '0;
            no_reg       <= '0;
            pend_reg     <= 1'b0;
            min_reg      <= '0;
            bit_reg      <= '0;
            sorted_reg   <= 1'b1;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            rk_reg       <= rk_next;
            zc_reg       <= zc_next;
            no_reg       <= no_next;
            pend_reg     <= pend_next;
            min_reg      <= min_next;
            bit_reg      <= bit_next;
            sorted_reg   <= sorted_next;
            first_reg    <= first_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wi_reg      <= wi_next;
        prev_reg    <= prev_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

// ===== rtl/core/brse_checker.sv =====
// port-level checks for the binary radix sort engine, bound to the top level
module brse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // the last input word closes the input
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last word");

    // a new result word only comes out of the emit phase, never while loading
    a_emit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result word appeared during loading");

endmodule

bind binary_radix_sort_engine brse_checker u_brse_checker (.*);

// ===== tb/tb_binary_radix_sort_engine.sv =====
// testbench for the binary radix sort engine: directed sets, random sets, result checking
`timescale 1ns / 1ps

module tb_binary_radix_sort_engine;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int HOLD_AFTER     = 40;
    localparam int RANDOM_ITEMS   = 300;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        brse_pkg::word_t value;
        logic            last;
        logic            typed;
        brse_pkg::word_t want;
    } stim_row_t;

    typedef struct packed {
        brse_pkg::word_t value;
        logic            last;
    } sorted_word_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    brse_pkg::word_t s_tdata  = '0;
    logic            s_tlast  = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    brse_pkg::word_t m_tdata;
    logic            m_tlast;

    binary_radix_sort_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of the engine state
    brse_pkg::word_t set_store [brse_pkg::MAX_ITEMS];
    int              set_count;
    int              set_floor;
    sorted_word_t    pending_sorted [$];

    int idle_phase    = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int words_sent    = 0;
    int words_dropped = 0;
    int sets_sorted   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int stall_cycles  = 0;

    function automatic bit set_in_order();
        for (int k = 1; k < set_count; k++)
            if (set_store[k-1] > set_store[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // stores one accepted word; on the last word normalizes, sorts and queues the run
    function automatic void absorb_word(brse_pkg::word_t v, logic l);
        brse_pkg::word_t zeros [$];
        brse_pkg::word_t ones [$];
        int              passes;
        if (set_count < brse_pkg::MAX_ITEMS) begin
            set_store[set_count] = v;
            set_count++;
            if ($signed(v) < set_floor)
                set_floor = $signed(v);
        end else begin
            words_dropped++;
        end
        if (!l)
            return;
        for (int k = 0; k < set_count; k++)
            set_store[k] = set_store[k] - brse_pkg::word_t'(set_floor);
        passes = 0;
        while (!set_in_order() && passes < brse_pkg::VALUE_BITS) begin
            zeros.delete();
            ones.delete();
            for (int k = 0; k < set_count; k++)
                if (set_store[k][passes])
                    ones.push_back(set_store[k]);
                else
                    zeros.push_back(set_store[k]);
            for (int k = 0; k < zeros.size(); k++)
                set_store[k] = zeros[k];
            for (int k = 0; k < ones.size(); k++)
                set_store[zeros.size() + k] = ones[k];
            passes++;
        end
        for (int k = 0; k < set_count; k++)
            pending_sorted.push_back('{value: set_store[k], last: (k == set_count - 1)});
        sets_sorted++;
        set_count = 0;
        set_floor = 0;
    endfunction

    task automatic push_word(brse_pkg::word_t v, logic l);
        int idle_pct;
        idle_pct = (idle_phase == 0) ? 24 : (idle_phase == 1) ? 63 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    function automatic brse_pkg::word_t random_value(int flavor);
        case (flavor)
            0: return $urandom;
            1: return brse_pkg::word_t'(int'($urandom_range(32)) - 16);
            2: return $urandom & 32'h7FFF_FFFF;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // receiver side: checks every result word and throttles m_tready
    always @(posedge aclk) begin
        sorted_word_t want;
        int           idle_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_sorted.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected word: data=%h last=%b", m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = pending_sorted.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last) begin
                        if (mismatches < 10)
                            $display("mismatch at word %0d: expected %h/%b got %h/%b",
                                     words_checked, want.value, want.last, m_tdata, m_tlast);
                        mismatches++;
                    end
                end
                words_checked++;
                // long hold-off so the engine stays in emission and input backs up
                if (words_checked == HOLD_AFTER && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            idle_pct = (idle_phase == 0) ? 63 : (idle_phase == 1) ? 24 : 0;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        stim_row_t       directed_rows [22];
        int              set_size;
        int              flavor;
        int              set_index;
        int              pick;
        brse_pkg::word_t v;

        directed_rows = '{
            // single-word sets: negatives normalize to zero
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
            '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
            // full-range spread
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
            // duplicate values in an unsorted set
            '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b1, 1'b0, 32'h0},
            // already in order: no pass needed
            '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0003, 1'b1, 1'b0, 32'h0},
            // descending with negatives, then a pair of alternating-bit patterns
            '{32'h0000_0009, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFF9, 1'b1, 1'b0, 32'h0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
            '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
        };

        set_count = 0;
        set_floor = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_phase = 0;
        foreach (directed_rows[i]) begin
            push_word(directed_rows[i].value, directed_rows[i].last);
            // typed rows are whole single-word sets, so predictor state stays empty
            if (directed_rows[i].typed)
                pending_sorted.push_back('{value: directed_rows[i].want, last: 1'b1});
            else
                absorb_word(directed_rows[i].value, directed_rows[i].last);
        end

        set_index = 0;
        while (words_sent < RANDOM_ITEMS + 22) begin
            pick = $urandom_range(99);
            if (set_index == 3)
                set_size = brse_pkg::MAX_ITEMS;
            else if (set_index == 7)
                set_size = brse_pkg::MAX_ITEMS + 2;   // oversized: extra words are dropped
            else if (pick < 78)
                set_size = $urandom_range(8, 1);
            else if (pick < 94)
                set_size = $urandom_range(20, 9);
            else if (pick < 97)
                set_size = brse_pkg::MAX_ITEMS;
            else
                set_size = $urandom_range(brse_pkg::MAX_ITEMS + 4, brse_pkg::MAX_ITEMS + 1);
            flavor = $urandom_range(3);
            for (int k = 0; k < set_size; k++) begin
                idle_phase = (words_sent < 120) ? 0 : (words_sent < 220) ? 1 : 2;
                v = random_value(flavor);
                push_word(v, k == set_size - 1);
                absorb_word(v, k == set_size - 1);
            end
            set_index++;
        end
        s_tvalid <= 1'b0;

        while (pending_sorted.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sorted %0d sets from %0d words (%0d dropped past capacity), %0d words checked",
                 sets_sorted, words_sent, words_dropped, words_checked);
        $display("idle patterns on both sides plus a %0d-cycle receiver hold-off", HOLD_CYCLES);
        if (mismatches == 0 && pending_sorted.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== binary_radix_sort_engine.f =====
rtl/core/brse_pkg.sv
rtl/core/brse_ram.sv
rtl/core/binary_radix_sort_engine.sv
rtl/core/brse_checker.sv
tb/tb_binary_radix_sort_engine.sv
